>>> rtl/cfe_pkg.sv
// Shared constants, codes and types of the best-fit custom float encoder.
package cfe_pkg;

    // Fixed widths that follow from binary64 and from the output word.
    localparam int F_W      = 53;   // significand with hidden bit
    localparam int S_W      = 13;   // signed shift count, covers every parameter value
    localparam int WORD_W   = 40;
    localparam int TB_W     = 6;
    localparam int EB_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;
    localparam int STAT_W   = 2;
    localparam int SH_W     = 6;    // shift amounts up to 63
    localparam int FAR_K    = 54;   // right shifts at or beyond this leave nothing

    localparam logic [10:0] BEXP_MAX  = 11'h7FF;
    localparam int          EXP_BIAS1 = 1075;
    localparam int          SUBN_P    = -1074;

    localparam int DEF_MAX_EXP_BITS      = 8;
    localparam int DEF_MAX_MANTISSA_BITS = 30;

    localparam logic [TB_W-1:0] RST_TOTAL_BITS = 6'd16;
    localparam logic [EB_W-1:0] RST_EXP_BITS   = 4'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_BITS   = 2'd1;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_FMT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FINITE = 2'd2;

    // One evaluated candidate, handed from the shift stage to the compare stage.
    typedef struct packed {
        logic           valid;
        logic           fit;
        logic           exact;
        logic           far;
        logic [F_W-1:0] mv;
        logic [F_W-1:0] rem;
        logic [F_W-1:0] half;
    } t_cand;

endpackage

>>> rtl/cfe_cand.sv
// Shift stage: rounds the significand for one candidate exponent and checks the fit.
module cfe_cand import cfe_pkg::*; #(
    parameter int MAX_EXP_BITS = DEF_MAX_EXP_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_issue,
    input  logic signed [S_W-1:0]        i_s,
    input  logic signed [MAX_EXP_BITS:0] i_e,
    input  logic [F_W-1:0]               i_f,
    input  logic [SH_W-1:0]              i_m,
    output t_cand                        o_cand,
    output logic signed [MAX_EXP_BITS:0] o_e
);

    t_cand               n_cand;
    t_cand               r_cand;
    logic signed [MAX_EXP_BITS:0] r_e;
    logic signed [S_W-1:0] t_full;
    logic signed [S_W-1:0] k_full;
    logic [SH_W-1:0]     t6;
    logic [SH_W-1:0]     k6;
    logic [F_W:0]        g;
    logic [F_W:0]        h;
    logic [F_W:0]        msk;
    logic [F_W:0]        q;

    always_comb begin
        t_full = $signed({{(S_W-SH_W){1'b0}}, i_m}) - i_s;
        k_full = -i_s;
        t6     = t_full[SH_W-1:0];
        k6     = k_full[SH_W-1:0];
        h      = (F_W+1)'(1) << (k6 - SH_W'(1));
        g      = {1'b0, i_f} + h;
        msk    = ((F_W+1)'(1) << k6) - (F_W+1)'(1);
        q      = g >> k6;

        n_cand       = '0;
        n_cand.valid = i_issue;
        if (!i_s[S_W-1]) begin
            // Left shift: exact, fits only if the shifted value stays below 2^m.
            n_cand.exact = 1'b1;
            n_cand.fit   = (i_s <= $signed({{(S_W-SH_W){1'b0}}, i_m}))
                           && ((i_f >> t6) == '0);
            n_cand.mv    = i_f << i_s[SH_W-1:0];
        end else if (k_full >= S_W'(FAR_K)) begin
            // Everything shifts out: mantissa zero, error is the whole value.
            n_cand.far = 1'b1;
            n_cand.fit = 1'b1;
        end else begin
            n_cand.mv   = q[F_W-1:0];
            n_cand.rem  = (g & msk) >> 0 == '0 ? '0 : F_W'(g & msk);
            n_cand.half = h[F_W-1:0];
            n_cand.fit  = (q >> i_m) == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.valid <= 1'b0;
        end else begin
            r_cand.valid <= n_cand.valid;
        end
        r_cand.fit   <= n_cand.fit;
        r_cand.exact <= n_cand.exact;
        r_cand.far   <= n_cand.far;
        r_cand.mv    <= n_cand.mv;
        r_cand.rem   <= n_cand.rem;
        r_cand.half  <= n_cand.half;
        r_e          <= i_e;
    end

    assign o_cand = r_cand;
    assign o_e    = r_e;

endmodule

>>> rtl/cfe_best.sv
// Compare stage: forms the exact error of a candidate and keeps the best one.
module cfe_best import cfe_pkg::*; #(
    parameter int MAX_EXP_BITS      = DEF_MAX_EXP_BITS,
    parameter int MAX_MANTISSA_BITS = DEF_MAX_MANTISSA_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  t_cand                             i_cand,
    input  logic signed [MAX_EXP_BITS:0]      i_e,
    input  logic [F_W-1:0]                    i_f,
    output logic signed [MAX_EXP_BITS:0]      o_best_e,
    output logic [MAX_MANTISSA_BITS-1:0]      o_best_m
);

    logic                              r_have;
    logic [F_W-1:0]                    r_best_d;
    logic signed [MAX_EXP_BITS:0]      r_best_e;
    logic [MAX_MANTISSA_BITS-1:0]      r_best_m;
    logic [F_W-1:0]                    d;
    logic                              take;

    always_comb begin
        if (i_cand.far) begin
            d = i_f;
        end else if (i_cand.exact) begin
            d = '0;
        end else if (i_cand.rem <= i_cand.half) begin
            d = i_cand.half - i_cand.rem;
        end else begin
            d = i_cand.rem - i_cand.half;
        end
        // Strict compare keeps the lower exponent on a tie.
        take = i_cand.valid && i_cand.fit && (!r_have || (d < r_best_d));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_have   <= 1'b0;
            r_best_e <= '0;
            r_best_m <= '0;
            r_best_d <= '0;
        end else if (take) begin
            r_have   <= 1'b1;
            r_best_e <= i_e;
            r_best_m <= i_cand.mv[MAX_MANTISSA_BITS-1:0];
            r_best_d <= d;
        end
    end

    assign o_best_e = r_best_e;
    assign o_best_m = r_best_m;

endmodule

>>> rtl/custom_float_encode_best_fit_top.sv
// Top level of the best-fit custom float encoder: registers, sequencer and packing.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------------------
//  input    | start, busy                   | i_value_bits[63:0]
//  result   | o_done (one-cycle strobe)     | o_encoded_word[39:0], o_status[1:0]
//  config   | i_cfg_valid, o_cfg_ready      | i_cfg_index[1:0], i_cfg_data[5:0]
//
// A transaction on the input channel takes place when start is high and busy
// is low. A bad format, a non-finite input or a zero is answered without a
// search, with o_done high in the cycle after the accepting edge.
// Any other value walks every candidate exponent, one per cycle through a
// shared shift stage and a compare stage. o_done marks the result for
// exactly one cycle; o_encoded_word and o_status keep it until the next
// result, and the receiver cannot stall it. Reset is synchronous and
// active low; it restores total_bits to 16 and exp_bits to 4 and returns
// the sequencer to idle. The configuration channel is always ready.
module custom_float_encode_best_fit_top import cfe_pkg::*; #(
    parameter int MAX_EXP_BITS      = DEF_MAX_EXP_BITS,
    parameter int MAX_MANTISSA_BITS = DEF_MAX_MANTISSA_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [63:0]           i_value_bits,
    output logic                  o_done,
    output logic [WORD_W-1:0]     o_encoded_word,
    output logic [STAT_W-1:0]     o_status,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    localparam int E_W = MAX_EXP_BITS + 1;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_PACK} t_state;

    t_state                r_state, n_state;
    logic [TB_W-1:0]       r_tb, n_tb;
    logic [EB_W-1:0]       r_eb, n_eb;
    logic [F_W-1:0]        r_f, n_f;
    logic                  r_sign, n_sign;
    logic [SH_W-1:0]       r_m, n_m;
    logic signed [S_W-1:0] r_s, n_s;
    logic signed [E_W-1:0] r_e, n_e;
    logic [E_W-1:0]        r_max_e, n_max_e;
    logic                  r_done, n_done;
    logic [WORD_W-1:0]     r_word, n_word;
    logic [STAT_W-1:0]     r_stat, n_stat;

    logic                  accept;
    logic signed [7:0]     m_s;
    logic                  bad_fmt;
    logic [10:0]           bexp;
    logic [51:0]           frac;
    logic signed [S_W-1:0] p_s;
    logic [E_W-1:0]        max_e;
    logic                  issue;
    logic                  clear;
    logic                  e_neg;
    logic [E_W-1:0]        abs_e;

    t_cand                 cand;
    logic signed [E_W-1:0] cand_e;
    logic signed [E_W-1:0] best_e;
    logic [MAX_MANTISSA_BITS-1:0] best_m;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign issue       = (r_state == S_RUN);

    // The format check uses the registers only; it comes before the input is examined.
    assign m_s     = $signed({2'b00, r_tb}) - 8'sd2 - $signed({4'b0000, r_eb});
    assign bad_fmt = (m_s < 8'sd1) || (int'(m_s) > MAX_MANTISSA_BITS)
                     || (int'(r_eb) > MAX_EXP_BITS) || (int'(r_tb) > WORD_W);

    assign bexp  = i_value_bits[62:52];
    assign frac  = i_value_bits[51:0];
    assign p_s   = (bexp == '0) ? S_W'(SUBN_P)
                                : $signed({{(S_W-11){1'b0}}, bexp}) - S_W'(EXP_BIAS1);
    assign max_e = (E_W'(1) << r_eb) - E_W'(1);

    // Magnitude and sign of the winning exponent for packing.
    assign e_neg = best_e[E_W-1];
    assign abs_e = e_neg ? E_W'(-best_e) : E_W'(best_e);

    assign clear = accept;

    always_comb begin
        n_state = r_state;
        n_tb    = r_tb;
        n_eb    = r_eb;
        n_f     = r_f;
        n_sign  = r_sign;
        n_m     = r_m;
        n_s     = r_s;
        n_e     = r_e;
        n_max_e = r_max_e;
        n_done  = 1'b0;
        n_word  = r_word;
        n_stat  = r_stat;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TOTAL_BITS: n_tb = i_cfg_data[TB_W-1:0];
                REG_EXP_BITS:   n_eb = i_cfg_data[EB_W-1:0];
                default:        ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (bad_fmt) begin
                        n_done = 1'b1;
                        n_word = '0;
                        n_stat = ST_BAD_FMT;
                    end else if (bexp == BEXP_MAX) begin
                        n_done = 1'b1;
                        n_word = '0;
                        n_stat = ST_NOT_FINITE;
                    end else if ((bexp == '0) && (frac == '0)) begin
                        n_done = 1'b1;
                        n_word = '0;
                        n_stat = ST_OK;
                    end else begin
                        // Walk exponents upward from -max_e; the shift count
                        // P + m - e drops by one per candidate.
                        n_f     = {(bexp != '0), frac};
                        n_sign  = i_value_bits[63];
                        n_m     = m_s[SH_W-1:0];
                        n_max_e = max_e;
                        n_e     = -$signed(max_e);
                        n_s     = p_s + $signed({{(S_W-SH_W){1'b0}}, m_s[SH_W-1:0]})
                                  + $signed({{(S_W-E_W){1'b0}}, max_e});
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_s = r_s - S_W'(1);
                n_e = r_e + E_W'(1);
                if (r_e == $signed(r_max_e)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_PACK;
            end
            S_PACK: begin
                n_done  = 1'b1;
                n_stat  = ST_OK;
                n_word  = (WORD_W'(r_sign) << (r_tb - TB_W'(1)))
                        | (WORD_W'(e_neg) << (r_tb - TB_W'(2)))
                        | (WORD_W'(abs_e) << r_m)
                        | WORD_W'(best_m);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tb    <= RST_TOTAL_BITS;
            r_eb    <= RST_EXP_BITS;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tb    <= n_tb;
            r_eb    <= n_eb;
            r_done  <= n_done;
        end
        r_f     <= n_f;
        r_sign  <= n_sign;
        r_m     <= n_m;
        r_s     <= n_s;
        r_e     <= n_e;
        r_max_e <= n_max_e;
        r_word  <= n_word;
        r_stat  <= n_stat;
    end

    cfe_cand #(
        .MAX_EXP_BITS (MAX_EXP_BITS)
    ) u_cand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .i_s     (r_s),
        .i_e     (r_e),
        .i_f     (r_f),
        .i_m     (r_m),
        .o_cand  (cand),
        .o_e     (cand_e)
    );

    cfe_best #(
        .MAX_EXP_BITS      (MAX_EXP_BITS),
        .MAX_MANTISSA_BITS (MAX_MANTISSA_BITS)
    ) u_best (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (clear),
        .i_cand   (cand),
        .i_e      (cand_e),
        .i_f      (r_f),
        .o_best_e (best_e),
        .o_best_m (best_m)
    );

    assign o_done         = r_done;
    assign o_encoded_word = r_word;
    assign o_status       = r_stat;

endmodule
